FILE: hw/rtl/wav_pcm_stream_decoder_top_defines.svh
// ---------------------------------------------------------------------------
// wav pcm stream decoder assertion macros
// shared helpers for the concurrent checks in the rtl
// ---------------------------------------------------------------------------
`ifndef WAV_PCM_STREAM_DECODER_TOP_DEFINES_SVH
`define WAV_PCM_STREAM_DECODER_TOP_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define WPSD_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define WPSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/wpsd_pkg.sv
// ---------------------------------------------------------------------------
// wpsd_pkg
// types and constants shared by the wav pcm stream decoder modules
// ---------------------------------------------------------------------------
package wpsd_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [8:0]  VOLUME_RESET = 9'd153;
   localparam logic [8:0]  UNITY_GAIN   = 9'd256;
   localparam logic [15:0] FMT_PCM      = 16'd1;

   typedef enum logic [2:0] {
      KIND_SAMPLE     = 3'd0,
      KIND_DONE       = 3'd1,
      KIND_BAD_HEADER = 3'd2,
      KIND_BAD_FORMAT = 3'd3,
      KIND_TRUNCATED  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_RIFF  = 3'd0,
      PH_CHUNK = 3'd1,
      PH_FMT   = 3'd2,
      PH_SKIP  = 3'd3,
      PH_DATA  = 3'd4,
      PH_END   = 3'd5
   } phase_type;

   // everything one byte produces: samples first, then at most one status
   typedef struct packed {
      logic [1:0]         n_res;
      logic               has_status;
      logic               mono;
      logic               stereo_ch;
      logic signed [15:0] sample;
      kind_type           status_kind;
   } wpsd_entry_type;

   // byte idx of a four character tag, first character at idx 0
   function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = tag[31:24];
         2'd1:    b = tag[23:16];
         2'd2:    b = tag[15:8];
         default: b = tag[7:0];
      endcase
      return b;
   endfunction

endpackage

FILE: hw/rtl/wpsd_serializer.sv
// ---------------------------------------------------------------------------
// wpsd_serializer
// holds one byte's results and hands them out one word per cycle while the result port is ready
// ---------------------------------------------------------------------------
`include "wav_pcm_stream_decoder_top_defines.svh"

module wpsd_serializer
   import wpsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wpsd_entry_type     entry,
   output logic               ser_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_channel,
   output logic [2:0]         rsp_kind,
   output logic               rsp_last
);

   wpsd_entry_type     pend_ff;
   logic               pend_valid_ff, pend_valid_in;
   logic [1:0]         idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_channel_ff, rsp_channel_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [1:0] n_samp;
   logic       out_load;
   logic       is_last;
   logic       release_pend;

   assign n_samp       = pend_ff.n_res - {1'b0, pend_ff.has_status};
   assign out_load     = !rsp_valid_ff || rsp_ready;
   assign is_last      = idx_ff == (pend_ff.n_res - 2'd1);
   assign release_pend = pend_valid_ff && out_load && is_last;
   assign ser_ready    = !pend_valid_ff || release_pend;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_last_in    = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = pend_valid_ff;
         rsp_last_in  = is_last;
         if (idx_ff < n_samp) begin
            rsp_sample_in  = pend_ff.sample;
            rsp_channel_in = pend_ff.mono ? idx_ff[0] : pend_ff.stereo_ch;
            rsp_kind_in    = KIND_SAMPLE;
         end else begin
            rsp_sample_in  = '0;
            rsp_channel_in = 1'b0;
            rsp_kind_in    = pend_ff.status_kind;
         end
      end

      pend_valid_in = pend_valid_ff;
      idx_in        = idx_ff;
      if (push) begin
         pend_valid_in = 1'b1;
         idx_in        = 2'd0;
      end else if (release_pend) begin
         pend_valid_in = 1'b0;
         idx_in        = 2'd0;
      end else if (out_load && pend_valid_ff) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         pend_ff <= entry;
      end
      rsp_sample_ff  <= rsp_sample_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sample  = rsp_sample_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_last    = rsp_last_ff;

   `WPSD_ASSERT_HOLDS(a_pend_not_empty, clock, reset, pend_valid_ff, pend_ff.n_res != 2'd0, "pending word with no results")
   `WPSD_ASSERT_HOLDS(a_idx_in_range, clock, reset, pend_valid_ff, idx_ff < pend_ff.n_res, "result index past count")
   `WPSD_ASSERT_HOLDS(a_status_zero, clock, reset, rsp_valid_ff && (rsp_kind_ff != KIND_SAMPLE), (rsp_sample_ff == 16'sd0) && !rsp_channel_ff, "status word carries sample data")

endmodule

FILE: hw/rtl/wpsd_parser.sv
// ---------------------------------------------------------------------------
// wpsd_parser
// input register, riff/wave chunk walker and sample scaling for one byte
// ---------------------------------------------------------------------------
`include "wav_pcm_stream_decoder_top_defines.svh"

module wpsd_parser
   import wpsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_file_byte,
   input  logic           req_first_byte,
   input  logic           req_end_of_file,
   input  logic [8:0]     gain,
   input  logic           ser_ready,
   output logic           push,
   output wpsd_entry_type entry
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       in_eof_ff;
   logic       fire;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hc_ff, hc_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] cbl_ff, cbl_in;
   logic [4:0]  coff_ff, coff_in;      // saturates at 16 outside the data chunk
   logic [15:0] fmt_ff, fmt_in;
   logic [15:0] chans_ff, chans_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] dbl_ff, dbl_in;
   logic [7:0]  low_ff, low_in;

   // state as seen by this byte, after a restart if it opens a file
   phase_type   cur_phase;
   logic [3:0]  cur_hc;
   logic [31:0] cur_tag, cur_cbl, cur_dbl;
   logic [4:0]  cur_coff;
   logic [15:0] cur_fmt, cur_chans, cur_bits;
   logic [7:0]  cur_low;

   logic [7:0]  b;
   logic [31:0] tag_n, cbl_n, dbl_n, cbl_dec, dbl_dec;
   logic        fmt_ok;
   logic [1:0]  n_samp;
   logic        fin;
   kind_type    fin_kind;
   logic signed [15:0] samp_val;
   logic        stereo_ch;

   // sample arithmetic
   logic signed [7:0]  d8;
   logic signed [17:0] prod8;
   logic [15:0] raw16, mag16, q16;
   logic [24:0] prod16;
   logic signed [15:0] s16;

   assign fire      = in_valid_ff && ser_ready;
   assign req_ready = !in_valid_ff || fire;
   assign b         = in_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_file_byte;
         in_first_ff <= req_first_byte;
         in_eof_ff   <= req_end_of_file;
      end
   end

   always_comb begin
      if (in_first_ff) begin
         cur_phase = PH_RIFF;
         cur_hc    = '0;
         cur_tag   = '0;
         cur_cbl   = '0;
         cur_coff  = '0;
         cur_fmt   = '0;
         cur_chans = '0;
         cur_bits  = '0;
         cur_dbl   = '0;
         cur_low   = '0;
      end else begin
         cur_phase = phase_ff;
         cur_hc    = hc_ff;
         cur_tag   = tag_ff;
         cur_cbl   = cbl_ff;
         cur_coff  = coff_ff;
         cur_fmt   = fmt_ff;
         cur_chans = chans_ff;
         cur_bits  = bits_ff;
         cur_dbl   = dbl_ff;
         cur_low   = low_ff;
      end
   end

   // 8-bit: recentre and scale, exact
   assign d8    = $signed({~b[7], b[6:0]});
   assign prod8 = d8 * $signed({1'b0, gain});

   // 16-bit: scale the magnitude, truncate toward zero
   assign raw16  = {b, cur_low};
   assign mag16  = raw16[15] ? (16'd0 - raw16) : raw16;
   assign prod16 = mag16 * gain;
   assign q16    = prod16[23:8];
   assign s16    = $signed(raw16[15] ? (16'd0 - q16) : q16);

   assign fmt_ok  = (cur_fmt == FMT_PCM) && ((cur_chans == 16'd1) || (cur_chans == 16'd2))
                    && ((cur_bits == 16'd8) || (cur_bits == 16'd16));
   assign cbl_dec = cur_cbl - 32'd1;
   assign dbl_dec = cur_dbl - 32'd1;

   always_comb begin
      phase_in  = cur_phase;
      hc_in     = cur_hc;
      tag_in    = cur_tag;
      cbl_in    = cur_cbl;
      coff_in   = cur_coff;
      fmt_in    = cur_fmt;
      chans_in  = cur_chans;
      bits_in   = cur_bits;
      dbl_in    = cur_dbl;
      low_in    = cur_low;
      tag_n     = cur_tag;
      cbl_n     = cur_cbl;
      dbl_n     = cur_dbl;
      n_samp    = 2'd0;
      samp_val  = '0;
      stereo_ch = 1'b0;
      fin       = 1'b0;
      fin_kind  = KIND_DONE;

      case (cur_phase)
         PH_RIFF: begin
            if ((cur_hc < 4'd4 && b != tag_byte(TAG_RIFF, cur_hc[1:0])) ||
                (cur_hc >= 4'd8 && cur_hc < 4'd12 && b != tag_byte(TAG_WAVE, cur_hc[1:0]))) begin
               fin      = 1'b1;
               fin_kind = KIND_BAD_HEADER;
               phase_in = PH_END;
            end else if (cur_hc == 4'd11) begin
               hc_in    = '0;
               phase_in = PH_CHUNK;
            end else begin
               hc_in = cur_hc + 4'd1;
            end
         end
         PH_CHUNK: begin
            if (!cur_hc[2]) begin
               tag_n = {cur_tag[23:0], b};
            end else begin
               cbl_n[{cur_hc[1:0], 3'b000} +: 8] = cur_cbl[{cur_hc[1:0], 3'b000} +: 8] | b;
            end
            tag_in = tag_n;
            cbl_in = cbl_n;
            hc_in  = cur_hc + 4'd1;
            if (cur_hc == 4'd7) begin
               hc_in   = '0;
               coff_in = '0;
               if (tag_n == TAG_DATA) begin
                  if (!fmt_ok || cbl_n == 32'd0) begin
                     fin      = 1'b1;
                     fin_kind = KIND_BAD_FORMAT;
                     phase_in = PH_END;
                  end else begin
                     // odd trailing byte of 16-bit data is dropped
                     dbl_n  = (cur_bits == 16'd16) ? {cbl_n[31:1], 1'b0} : cbl_n;
                     dbl_in = dbl_n;
                     if (dbl_n == 32'd0) begin
                        fin      = 1'b1;
                        fin_kind = KIND_DONE;
                        phase_in = PH_END;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end else if (cbl_n != 32'd0) begin
                  phase_in = (tag_n == TAG_FMT) ? PH_FMT : PH_SKIP;
               end else begin
                  tag_in = '0;
                  cbl_in = '0;
               end
            end
         end
         PH_FMT, PH_SKIP: begin
            if (cur_phase == PH_FMT && !cur_coff[4]) begin
               if (cur_coff[3:0] < 4'd2) begin
                  fmt_in[{cur_coff[0], 3'b000} +: 8] = b;
               end else if (cur_coff[3:0] < 4'd4) begin
                  chans_in[{cur_coff[0], 3'b000} +: 8] = b;
               end else if (cur_coff[3:0] >= 4'd14) begin
                  bits_in[{cur_coff[0], 3'b000} +: 8] = b;
               end
            end
            coff_in = cur_coff[4] ? cur_coff : cur_coff + 5'd1;
            cbl_in  = cbl_dec;
            if (cbl_dec == 32'd0) begin
               phase_in = PH_CHUNK;
               tag_in   = '0;
               coff_in  = '0;
            end
         end
         PH_DATA: begin
            if (cur_bits == 16'd8) begin
               n_samp    = (cur_chans == 16'd1) ? 2'd2 : 2'd1;
               samp_val  = prod8[15:0];
               stereo_ch = cur_coff[0];
            end else if (!cur_coff[0]) begin
               low_in = b;
            end else begin
               n_samp    = (cur_chans == 16'd1) ? 2'd2 : 2'd1;
               samp_val  = s16;
               stereo_ch = cur_coff[1];
            end
            coff_in = cur_coff + 5'd1;
            dbl_in  = dbl_dec;
            if (dbl_dec == 32'd0) begin
               fin      = 1'b1;
               fin_kind = KIND_DONE;
               phase_in = PH_END;
            end
         end
         default: begin
         end
      endcase

      if (in_eof_ff && phase_in != PH_END) begin
         fin = 1'b1;
         if (phase_in == PH_RIFF) begin
            fin_kind = KIND_BAD_HEADER;
         end else if (phase_in == PH_DATA) begin
            fin_kind = KIND_TRUNCATED;
         end else begin
            fin_kind = KIND_BAD_FORMAT;
         end
         phase_in = PH_END;
      end
   end

   assign entry.n_res       = n_samp + {1'b0, fin};
   assign entry.has_status  = fin;
   assign entry.mono        = cur_chans == 16'd1;
   assign entry.stereo_ch   = stereo_ch;
   assign entry.sample      = samp_val;
   assign entry.status_kind = fin_kind;
   assign push              = fire && (entry.n_res != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF;
         hc_ff    <= '0;
         tag_ff   <= '0;
         cbl_ff   <= '0;
         coff_ff  <= '0;
         fmt_ff   <= '0;
         chans_ff <= '0;
         bits_ff  <= '0;
         dbl_ff   <= '0;
         low_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         hc_ff    <= hc_in;
         tag_ff   <= tag_in;
         cbl_ff   <= cbl_in;
         coff_ff  <= coff_in;
         fmt_ff   <= fmt_in;
         chans_ff <= chans_in;
         bits_ff  <= bits_in;
         dbl_ff   <= dbl_in;
         low_ff   <= low_in;
      end
   end

   `WPSD_ASSERT_NEXT(a_end_after_status, clock, reset, push && entry.has_status, phase_ff == PH_END, "status given but parser not finished")
   `WPSD_ASSERT_NEXT(a_stage_holds, clock, reset, in_valid_ff && !fire, in_valid_ff && $stable(in_byte_ff), "input word lost while stalled")

endmodule

FILE: hw/rtl/wav_pcm_stream_decoder_top.sv
// path: a byte passes the input register and the pending register before its first result reaches the output register
// throughput: one file byte per cycle while each byte gives at most one result and rsp_ready stays high
// a byte giving more than one result holds the next byte back until its last result is taken (8-bit mono: two per byte)
// the single result port sets the rate; the parser itself never stalls on its own
// reset: synchronous, parser back to the riff header, volume to 153, pipeline emptied
// ---------------------------------------------------------------------------
// wav_pcm_stream_decoder_top
// riff/wave pcm byte stream decoder with volume scaling and status reporting
// ---------------------------------------------------------------------------
module wav_pcm_stream_decoder_top
   import wpsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_file_byte,
   input  logic               req_first_byte,
   input  logic               req_end_of_file,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_channel,
   output logic [2:0]         rsp_kind,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [8:0]         csr_write_data
);

   logic [8:0]     volume_ff, volume_in;
   logic [8:0]     gain;
   logic           ser_ready;
   logic           push;
   wpsd_entry_type entry;

   assign volume_in = csr_write_enable ? csr_write_data : volume_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= VOLUME_RESET;
      end else begin
         volume_ff <= volume_in;
      end
   end

   // anything above unity acts as unity
   assign gain = (volume_ff > UNITY_GAIN) ? UNITY_GAIN : volume_ff;

   wpsd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_file_byte   (req_file_byte),
      .req_first_byte  (req_first_byte),
      .req_end_of_file (req_end_of_file),
      .gain            (gain),
      .ser_ready       (ser_ready),
      .push            (push),
      .entry           (entry)
   );

   wpsd_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .entry       (entry),
      .ser_ready   (ser_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_sample  (rsp_sample),
      .rsp_channel (rsp_channel),
      .rsp_kind    (rsp_kind),
      .rsp_last    (rsp_last)
   );

endmodule

FILE: test/wav_result_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// wav result checker
// follows the wav decoder byte by byte, predicts the sample and status words
// that each accepted byte should give and compares them with the result port
// ---------------------------------------------------------------------------
module wav_result_checker
   import wpsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_file_byte,
   input  logic               req_first_byte,
   input  logic               req_end_of_file,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_sample,
   input  logic               rsp_channel,
   input  logic [2:0]         rsp_kind,
   input  logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [8:0]         csr_write_data,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic signed [15:0] sample;
      logic               channel;
      kind_type           kind;
      logic               last;
   } pcm_word_type;

   pcm_word_type  expected_words[$];
   pcm_word_type  byte_words[$];

   logic [8:0]  vol_reg;
   phase_type   phase;
   logic [3:0]  hdr_cnt;
   logic [31:0] tag_acc;
   logic [31:0] body_left;
   logic [31:0] body_off;
   logic [31:0] audio_left;
   logic [15:0] fmt_code;
   logic [15:0] n_chan;
   logic [15:0] n_bits;
   logic [7:0]  low_hold;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic clear_parser();
      phase      = PH_RIFF;
      hdr_cnt    = '0;
      tag_acc    = '0;
      body_left  = '0;
      body_off   = '0;
      audio_left = '0;
      fmt_code   = '0;
      n_chan     = '0;
      n_bits     = '0;
      low_hold   = '0;
   endtask

   function automatic int gain_now();
      return (vol_reg > UNITY_GAIN) ? int'(UNITY_GAIN) : int'(vol_reg);
   endfunction

   // 16-bit samples: magnitude scaled, truncated toward zero
   function automatic logic [15:0] scale_word(input logic signed [15:0] v);
      int mag;
      int q;
      mag = (v < 0) ? -int'(v) : int'(v);
      q   = (mag * gain_now()) / 256;
      return (v < 0) ? 16'(-q) : 16'(q);
   endfunction

   task automatic put_word(input logic [15:0] s, input logic ch, input kind_type k);
      pcm_word_type w;
      if (byte_words.size() < 3) begin
         w.sample  = s;
         w.channel = ch;
         w.kind    = k;
         w.last    = 1'b0;
         byte_words.push_back(w);
      end
   endtask

   task automatic stop_with(input kind_type k);
      put_word('0, 1'b0, k);
      phase = PH_END;
   endtask

   // mono goes out twice, left then right
   task automatic put_sample(input logic [15:0] s, input logic stereo_ch);
      if (n_chan == 16'd1) begin
         put_word(s, 1'b0, KIND_SAMPLE);
         put_word(s, 1'b1, KIND_SAMPLE);
      end else begin
         put_word(s, stereo_ch, KIND_SAMPLE);
      end
   endtask

   task automatic start_audio();
      if (!(body_left != 0 && fmt_code == FMT_PCM && (n_chan == 16'd1 || n_chan == 16'd2) &&
            (n_bits == 16'd8 || n_bits == 16'd16))) begin
         stop_with(KIND_BAD_FORMAT);
         return;
      end
      audio_left = (n_bits == 16'd16) ? {body_left[31:1], 1'b0} : body_left;
      body_off   = '0;
      if (audio_left == 0)
         stop_with(KIND_DONE);
      else
         phase = PH_DATA;
   endtask

   task automatic audio_byte(input logic [7:0] b);
      logic [31:0] off;
      int          v8;
      off = body_off;
      if (n_bits == 16'd8) begin
         v8 = (int'(b) - 128) * gain_now();
         put_sample(16'(v8), off[0]);
      end else if (!off[0]) begin
         low_hold = b;
      end else begin
         put_sample(scale_word({b, low_hold}), off[1]);
      end
      body_off   = off + 1;
      audio_left = audio_left - 1;
      if (audio_left == 0)
         stop_with(KIND_DONE);
   endtask

   task automatic parse_byte(input logic [7:0] b);
      int          k;
      logic [31:0] o;
      case (phase)
         PH_RIFF: begin
            k = int'(hdr_cnt);
            if (k < 4 && b != 8'(TAG_RIFF >> (8 * (3 - k)))) begin
               stop_with(KIND_BAD_HEADER);
               return;
            end
            if (k >= 8 && k < 12 && b != 8'(TAG_WAVE >> (8 * (11 - k)))) begin
               stop_with(KIND_BAD_HEADER);
               return;
            end
            hdr_cnt = hdr_cnt + 4'd1;
            if (hdr_cnt >= 12) begin
               hdr_cnt = '0;
               phase   = PH_CHUNK;
            end
         end
         PH_CHUNK: begin
            if (hdr_cnt < 4)
               tag_acc = {tag_acc[23:0], b};
            else
               body_left = body_left | (32'(b) << (8 * (int'(hdr_cnt) - 4)));
            hdr_cnt = hdr_cnt + 4'd1;
            if (hdr_cnt >= 8) begin
               hdr_cnt  = '0;
               body_off = '0;
               if (tag_acc == TAG_DATA)
                  start_audio();
               else if (body_left != 0)
                  phase = (tag_acc == TAG_FMT) ? PH_FMT : PH_SKIP;
               if (phase == PH_CHUNK) begin
                  tag_acc   = '0;
                  body_left = '0;
               end
            end
         end
         PH_FMT, PH_SKIP: begin
            // only the format, channel and bit fields of the fmt body are kept
            if (phase == PH_FMT && body_off < 16) begin
               o = body_off;
               if (o < 2) begin
                  if (o[0]) fmt_code[15:8] = b; else fmt_code[7:0] = b;
               end else if (o < 4) begin
                  if (o[0]) n_chan[15:8] = b; else n_chan[7:0] = b;
               end else if (o >= 14) begin
                  if (o[0]) n_bits[15:8] = b; else n_bits[7:0] = b;
               end
            end
            body_off  = body_off + 1;
            body_left = body_left - 1;
            if (body_left == 0) begin
               phase    = PH_CHUNK;
               tag_acc  = '0;
               body_off = '0;
            end
         end
         PH_DATA: audio_byte(b);
         default: ;
      endcase
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic first, input logic eof);
      pcm_word_type w;
      byte_words.delete();
      if (first)
         clear_parser();
      parse_byte(b);
      if (eof) begin
         if (phase == PH_RIFF)
            stop_with(KIND_BAD_HEADER);
         else if (phase == PH_DATA)
            stop_with(KIND_TRUNCATED);
         else if (phase != PH_END)
            stop_with(KIND_BAD_FORMAT);
      end
      if (byte_words.size() > 0)
         byte_words[byte_words.size() - 1].last = 1'b1;
      foreach (byte_words[i]) begin
         w = byte_words[i];
         expected_words.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      pcm_word_type want;
      if (reset) begin
         vol_reg = VOLUME_RESET;
         clear_parser();
         expected_words.delete();
      end else begin
         // words leaving now belong to bytes predicted before this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report($sformatf("unexpected word sample %0d channel %0d kind %0d",
                                rsp_sample, rsp_channel, rsp_kind));
            end else begin
               want = expected_words.pop_front();
               if (rsp_sample !== want.sample)
                  report($sformatf("sample %0d, expected %0d", rsp_sample, want.sample));
               if (rsp_channel !== want.channel)
                  report($sformatf("channel %0d, expected %0d", rsp_channel, want.channel));
               if (rsp_kind !== want.kind)
                  report($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
               if (rsp_last !== want.last)
                  report($sformatf("last %0d, expected %0d", rsp_last, want.last));
            end
         end
         if (csr_write_enable)
            vol_reg = csr_write_data;
         if (req_valid && req_ready)
            predict_byte(req_file_byte, req_first_byte, req_end_of_file);
      end
      pending = expected_words.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// wav pcm stream decoder testbench
// feeds short wav files a byte at a time, good ones with random audio and
// broken ones (bad headers, bad formats, cut-short data, aborted files),
// under several volume settings, with random stalls on both channels
// ---------------------------------------------------------------------------
module testbench
   import wpsd_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_BYTES  = 74;
   localparam int PHASE_COUNT  = 5;
   localparam int HOLD_CYCLES  = 80;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic [7:0]         req_file_byte    = '0;
   logic               req_first_byte   = 1'b0;
   logic               req_end_of_file  = 1'b0;
   logic               rsp_ready        = 1'b0;
   logic               csr_write_enable = 1'b0;
   logic [8:0]         csr_write_data   = '0;
   logic               req_ready;
   logic               rsp_valid;
   logic signed [15:0] rsp_sample;
   logic               rsp_channel;
   logic [2:0]         rsp_kind;
   logic               rsp_last;
   int                 mismatches;
   int                 pending;

   int                 cycle_count = 0;
   int                 phase_no    = 0;
   bit                 calm        = 1'b0;
   bit                 held_once   = 1'b0;
   logic [7:0]         wav_bytes[$];

   wav_pcm_stream_decoder_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_file_byte    (req_file_byte),
      .req_first_byte   (req_first_byte),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .rsp_channel      (rsp_channel),
      .rsp_kind         (rsp_kind),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   wav_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_file_byte    (req_file_byte),
      .req_first_byte   (req_first_byte),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .rsp_channel      (rsp_channel),
      .rsp_kind         (rsp_kind),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (mismatches),
      .pending          (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: short random stalls, one long hold-off while bytes keep coming
   initial begin
      forever begin
         @(negedge clock);
         if (phase_no == 1 && !held_once) begin
            held_once = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_byte(input logic [7:0] b, input logic first, input logic eof);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_file_byte   <= b;
      req_first_byte  <= first;
      req_end_of_file <= eof;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_file(input bit with_eof);
      foreach (wav_bytes[i])
         send_byte(wav_bytes[i], i == 0, with_eof && i == wav_bytes.size() - 1);
   endtask

   // wait for every expected word, then for any byte still in flight
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_volume(input logic [8:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic add_le(input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++)
         wav_bytes.push_back(v[8 * i +: 8]);
   endtask

   task automatic add_tag(input logic [31:0] t);
      for (int i = 0; i < 4; i++)
         wav_bytes.push_back(t[31 - 8 * i -: 8]);
   endtask

   task automatic trim_to(input int n);
      while (wav_bytes.size() > n)
         void'(wav_bytes.pop_back());
   endtask

   function automatic logic [7:0] audio_value();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic build_random_file(output bit with_eof);
      int           style;
      int           flaw;
      int           fmt_len;
      int           data_len;
      int           n;
      logic [15:0]  fcode;
      logic [15:0]  nch;
      logic [15:0]  nbits;
      logic [31:0]  declared;
      logic [127:0] core;
      style    = $urandom_range(0, 9);
      flaw     = 0;
      fcode    = FMT_PCM;
      nch      = 16'($urandom_range(1, 2));
      nbits    = $urandom_range(0, 1) ? 16'd16 : 16'd8;
      fmt_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 20) : 16;
      data_len = $urandom_range(1, 12);
      declared = 32'(data_len);
      with_eof = 1'b1;
      wav_bytes.delete();
      if (style == 7) begin
         flaw = $urandom_range(0, 5);
         case (flaw)
            0: fcode = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
            1: nch = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(3, 8));
            2: nbits = $urandom_range(0, 1) ? 16'd0 : 16'(4 * $urandom_range(3, 8));
            3: declared = '0;
            4: fmt_len = $urandom_range(1, 15);
            default: ;
         endcase
      end
      if (style == 8)
         declared = $urandom | 32'h100;
      add_tag(TAG_RIFF);
      add_le($urandom, 4);
      add_tag(TAG_WAVE);
      // an unknown chunk to skip, sometimes empty
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(0, 3);
         add_le($urandom, 4);
         add_le(n, 4);
         repeat (n) wav_bytes.push_back(8'($urandom));
      end
      core = {nbits, 16'($urandom), 32'($urandom), 32'($urandom), nch, fcode};
      add_tag(TAG_FMT);
      add_le(fmt_len, 4);
      for (int i = 0; i < fmt_len; i++)
         wav_bytes.push_back(i < 16 ? core[8 * i +: 8] : 8'($urandom));
      add_tag(TAG_DATA);
      add_le(declared, 4);
      if (style == 7) begin
         // no audio follows the data chunk header; with flaw 5 the file ends before that header is complete
         if (flaw == 5)
            trim_to(wav_bytes.size() - $urandom_range(1, 8));
         return;
      end
      if (style == 8) begin
         repeat ($urandom_range(0, 8)) wav_bytes.push_back(audio_value());
         return;
      end
      repeat (data_len) wav_bytes.push_back(audio_value());
      if (style == 9) begin
         case ($urandom_range(0, 2))
            0: begin
               n = $urandom_range(0, 7);
               n = (n < 4) ? n : n + 4;
               wav_bytes[n] = wav_bytes[n] ^ 8'($urandom_range(1, 255));
            end
            1: trim_to($urandom_range(1, 11));
            default: begin
               wav_bytes.delete();
               repeat ($urandom_range(1, 4)) wav_bytes.push_back(8'($urandom));
            end
         endcase
      end else if (style == 6) begin
         // abandoned part way, the next file restarts the parser
         trim_to($urandom_range(1, wav_bytes.size() - 1));
         with_eof = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) wav_bytes.push_back(8'($urandom));
      end
   endtask

   initial begin
      int         sent;
      bit         eof_flag;
      logic [8:0] vol_plan[PHASE_COUNT];
      vol_plan = '{VOLUME_RESET, 9'd511, 9'd0, UNITY_GAIN, 9'($urandom_range(1, 255))};

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // wrong last letter of the riff tag
      wav_bytes = '{8'h52, 8'h49, 8'h46, 8'h58};
      send_file(1'b0);
      // single wrong byte that is also the end of the file
      send_byte(8'h00, 1'b1, 1'b1);
      // file ending inside the riff header
      wav_bytes = '{8'h52, 8'h49, 8'h46};
      send_file(1'b1);
      // end of file after the parser has finished gives nothing
      send_byte(8'hFF, 1'b0, 1'b1);
      // complete riff header, then the file ends before any chunk
      wav_bytes.delete();
      add_tag(TAG_RIFF);
      add_le(32'hFFFF_FFFF, 4);
      add_tag(TAG_WAVE);
      send_file(1'b1);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p > 0) begin
            settle();
            write_volume(vol_plan[p]);
         end
         phase_no <= p;
         calm     <= (p == PHASE_COUNT - 1);
         sent = 0;
         while (sent < PHASE_BYTES) begin
            build_random_file(eof_flag);
            send_file(eof_flag);
            sent += wav_bytes.size();
         end
      end

      settle();
      repeat (12) @(negedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
